// File: src/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// types and constants shared by the rms beat detector modules
// ----------------------------------------------------------------------------
package rbd_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int TIME_W     = 32;
   localparam int SUM_W      = 40;
   localparam int AVG_W      = 32;
   localparam int ROOT_W     = 16;
   localparam int ALPHA_W    = 16;
   localparam int RATIO_W    = 12;
   localparam int DEBOUNCE_W = 16;
   localparam int TOTAL_W    = 32;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int MUL_A_W    = 33;
   localparam int MUL_B_W    = 17;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;

   localparam int STEP_W     = 6;
   localparam int DIV_STEPS  = SUM_W;
   localparam int SQRT_STEPS = ROOT_W;

   localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = 16'd5243;
   localparam logic [RATIO_W-1:0]    RATIO_RESET    = 12'd640;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd200;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd2;

   localparam logic [ROOT_W-1:0] RMS_MAX = 16'd32768;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       block_end;
      logic [TIME_W-1:0]          time_ms;
   } req_type;

   typedef struct packed {
      logic                beat_flag;
      logic [ROOT_W-1:0]   block_rms;
      logic [ROOT_W-1:0]   average_level;
      logic [TOTAL_W-1:0]  beats_seen;
   } rsp_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_ACC   = 8'b0000_0010,
      S_DIV   = 8'b0000_0100,
      S_SQRT  = 8'b0000_1000,
      S_EMA   = 8'b0001_0000,
      S_AVG   = 8'b0010_0000,
      S_RATIO = 8'b0100_0000,
      S_DEC   = 8'b1000_0000
   } state_type;

endpackage

// File: src/rbd_arith.sv
// ----------------------------------------------------------------------------
// rbd_arith
// shared arithmetic unit: one signed multiplier and one compare-subtract
// ----------------------------------------------------------------------------
module rbd_arith #(
   parameter int W = 20
) (
   input  logic [W-1:0]                          sub_a,
   input  logic [W-1:0]                          sub_b,
   output logic [W-1:0]                          sub_diff,
   output logic                                  sub_ge,
   input  logic signed [rbd_pkg::MUL_A_W-1:0]    mul_a,
   input  logic signed [rbd_pkg::MUL_B_W-1:0]    mul_b,
   output logic signed [rbd_pkg::PROD_W-1:0]     mul_prod
);

   assign sub_ge   = (sub_a >= sub_b);
   assign sub_diff = sub_a - sub_b;
   assign mul_prod = rbd_pkg::PROD_W'(mul_a) * rbd_pkg::PROD_W'(mul_b);

endmodule

// File: src/rms_beat_detector_core.sv
// ----------------------------------------------------------------------------
// rms_beat_detector_core
// energy based beat detector over blocks of audio samples
// ----------------------------------------------------------------------------
// A sample that does not close a block is squared on the shared multiplier
// in the accept cycle, and the next cycle adds it to the block sum. A
// closing sample keeps req_stall high through the square, 40 restoring
// divide steps and 16 square root steps on the shared compare-subtract
// unit, then the running average and threshold products on the shared
// multiplier and the beat decision. The decision cycle waits while a
// previous result is still held on rsp.
module rms_beat_detector_core #(
   parameter int BLOCK_MAX = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rbd_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rbd_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rbd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rbd_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW = $clog2(BLOCK_MAX + 1);
   localparam int W  = (CW + 1 > 20) ? CW + 1 : 20;

   rbd_pkg::state_type state_ff, state_in;

   logic [rbd_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic [CW-1:0]                  div_ff, div_in;
   logic [rbd_pkg::SUM_W-1:0]      work_ff, work_in;
   logic [W-1:0]                   rem_ff, rem_in;
   logic [rbd_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic [rbd_pkg::STEP_W-1:0]     step_ff, step_in;
   logic signed [rbd_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                           end_ff, end_in;
   logic [rbd_pkg::TIME_W-1:0]     time_ff, time_in;
   logic [rbd_pkg::AVG_W-1:0]      avg_ff, avg_in;
   logic                           seeded_ff, seeded_in;
   logic [rbd_pkg::TIME_W-1:0]     last_ff, last_in;
   logic [rbd_pkg::TOTAL_W-1:0]    total_ff, total_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rbd_pkg::rsp_type               rsp_ff, rsp_in;

   logic [rbd_pkg::ALPHA_W-1:0]    alpha_ff, alpha_in;
   logic [rbd_pkg::RATIO_W-1:0]    ratio_ff, ratio_in;
   logic [rbd_pkg::DEBOUNCE_W-1:0] debounce_ff, debounce_in;

   logic [W-1:0]                   sub_a, sub_b, sub_diff;
   logic                           sub_ge;
   logic signed [rbd_pkg::MUL_A_W-1:0] mul_a;
   logic signed [rbd_pkg::MUL_B_W-1:0] mul_b;
   logic signed [rbd_pkg::PROD_W-1:0]  mul_prod;

   logic                           req_accept;
   logic                           csr_write;
   logic [rbd_pkg::SAMPLE_W:0]     sample_ext;
   logic [rbd_pkg::SAMPLE_W:0]     sample_mag;
   logic [rbd_pkg::SUM_W:0]        sum_wide;
   logic [rbd_pkg::SUM_W-1:0]      sum_sat;
   logic [CW-1:0]                  cnt_next;
   logic                           block_close;
   logic [rbd_pkg::AVG_W-1:0]      rms_wide;
   logic [rbd_pkg::AVG_W-1:0]      avg_base;
   logic signed [rbd_pkg::PROD_W-1:0] prod_shift;
   logic [rbd_pkg::SUM_W+3:0]      level_lhs;
   logic                           level_hit;
   logic [rbd_pkg::TIME_W-1:0]     elapsed;
   logic                           beat;
   logic                           rsp_free;

   rbd_arith #(
      .W (W)
   ) u_arith (
      .sub_a    (sub_a),
      .sub_b    (sub_b),
      .sub_diff (sub_diff),
      .sub_ge   (sub_ge),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   assign req_stall   = (state_ff != rbd_pkg::S_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign sample_ext = {req_payload.sample[rbd_pkg::SAMPLE_W-1], req_payload.sample};
   assign sample_mag = sample_ext[rbd_pkg::SAMPLE_W] ? (~sample_ext + 1'b1) : sample_ext;

   assign sum_wide    = {1'b0, sum_ff} + (rbd_pkg::SUM_W + 1)'(prod_ff[30:0]);
   assign sum_sat     = sum_wide[rbd_pkg::SUM_W] ? {rbd_pkg::SUM_W{1'b1}}
                                                 : sum_wide[rbd_pkg::SUM_W-1:0];
   assign cnt_next    = cnt_ff + 1'b1;
   assign block_close = end_ff || (cnt_next == CW'(BLOCK_MAX));

   assign rms_wide   = {root_ff, 16'b0};
   assign avg_base   = seeded_ff ? avg_ff : rms_wide;
   assign prod_shift = prod_ff >>> 16;
   assign level_lhs  = {4'b0, root_ff, 24'b0};
   assign level_hit  = level_lhs > prod_ff[rbd_pkg::SUM_W+3:0];
   assign elapsed    = time_ff - last_ff;
   assign beat       = level_hit && (elapsed > rbd_pkg::TIME_W'(debounce_ff));

   // shared unit operand selection
   always_comb begin
      sub_a = '0;
      sub_b = '0;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         rbd_pkg::S_IDLE: begin
            mul_a = rbd_pkg::MUL_A_W'(sample_mag);
            mul_b = sample_mag;
         end
         rbd_pkg::S_DIV: begin
            sub_a = {rem_ff[W-2:0], work_ff[rbd_pkg::SUM_W-1]};
            sub_b = W'(div_ff);
         end
         rbd_pkg::S_SQRT: begin
            sub_a = {rem_ff[W-3:0], work_ff[31:30]};
            sub_b = W'({root_ff, 2'b01});
         end
         rbd_pkg::S_EMA: begin
            mul_a = {1'b0, rms_wide} - {1'b0, avg_base};
            mul_b = {1'b0, alpha_ff};
         end
         rbd_pkg::S_RATIO: begin
            mul_a = {1'b0, avg_ff};
            mul_b = rbd_pkg::MUL_B_W'(ratio_ff);
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      div_in       = div_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      end_in       = end_ff;
      time_in      = time_ff;
      avg_in       = avg_ff;
      seeded_in    = seeded_ff;
      last_in      = last_ff;
      total_in     = total_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         rbd_pkg::S_IDLE: begin
            if (req_accept) begin
               prod_in  = mul_prod;
               end_in   = req_payload.block_end;
               time_in  = req_payload.time_ms;
               state_in = rbd_pkg::S_ACC;
            end
         end
         rbd_pkg::S_ACC: begin
            if (block_close) begin
               work_in  = sum_sat;
               div_in   = cnt_next;
               sum_in   = '0;
               cnt_in   = '0;
               rem_in   = '0;
               step_in  = '0;
               state_in = rbd_pkg::S_DIV;
            end else begin
               sum_in   = sum_sat;
               cnt_in   = cnt_next;
               state_in = rbd_pkg::S_IDLE;
            end
         end
         rbd_pkg::S_DIV: begin
            rem_in  = sub_ge ? sub_diff : sub_a;
            work_in = {work_ff[rbd_pkg::SUM_W-2:0], sub_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == rbd_pkg::STEP_W'(rbd_pkg::DIV_STEPS - 1)) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = rbd_pkg::S_SQRT;
            end
         end
         rbd_pkg::S_SQRT: begin
            rem_in  = sub_ge ? sub_diff : sub_a;
            root_in = {root_ff[rbd_pkg::ROOT_W-2:0], sub_ge};
            work_in = {work_ff[rbd_pkg::SUM_W-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == rbd_pkg::STEP_W'(rbd_pkg::SQRT_STEPS - 1)) begin
               state_in = rbd_pkg::S_EMA;
            end
         end
         rbd_pkg::S_EMA: begin
            prod_in   = mul_prod;
            avg_in    = avg_base;
            seeded_in = 1'b1;
            state_in  = rbd_pkg::S_AVG;
         end
         rbd_pkg::S_AVG: begin
            avg_in   = avg_ff + prod_shift[rbd_pkg::AVG_W-1:0];
            state_in = rbd_pkg::S_RATIO;
         end
         rbd_pkg::S_RATIO: begin
            prod_in  = mul_prod;
            state_in = rbd_pkg::S_DEC;
         end
         rbd_pkg::S_DEC: begin
            if (rsp_free) begin
               if (beat) begin
                  last_in  = time_ff;
                  total_in = total_ff + 1'b1;
               end
               rsp_in.beat_flag     = beat;
               rsp_in.block_rms     = root_ff;
               rsp_in.average_level = avg_ff[rbd_pkg::AVG_W-1:16];
               rsp_in.beats_seen    = beat ? total_ff + 1'b1 : total_ff;
               rsp_valid_in         = 1'b1;
               state_in             = rbd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rbd_pkg::S_IDLE;
         end
      endcase
   end

   // configuration registers
   always_comb begin
      alpha_in    = alpha_ff;
      ratio_in    = ratio_ff;
      debounce_in = debounce_ff;
      if (csr_write) begin
         unique case (csr_index)
            rbd_pkg::CSR_ALPHA:    alpha_in    = csr_data;
            rbd_pkg::CSR_RATIO:    ratio_in    = csr_data[rbd_pkg::RATIO_W-1:0];
            rbd_pkg::CSR_DEBOUNCE: debounce_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbd_pkg::S_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         avg_ff       <= '0;
         seeded_ff    <= 1'b0;
         last_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         alpha_ff     <= rbd_pkg::ALPHA_RESET;
         ratio_ff     <= rbd_pkg::RATIO_RESET;
         debounce_ff  <= rbd_pkg::DEBOUNCE_RESET;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         avg_ff       <= avg_in;
         seeded_ff    <= seeded_in;
         last_ff      <= last_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         alpha_ff     <= alpha_in;
         ratio_ff     <= ratio_in;
         debounce_ff  <= debounce_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
      end_ff  <= end_in;
      time_ff <= time_in;
      rsp_ff  <= rsp_in;
   end

   a_rsp_from_decision: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == rbd_pkg::S_DEC))
      else $error("result raised outside the decision step");

   a_count_below_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rbd_pkg::S_IDLE) |-> (cnt_ff < CW'(BLOCK_MAX)))
      else $error("open block count reached the block limit");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rbd_pkg::S_DIV) |-> (div_ff != '0))
      else $error("divide started with an empty block");

   a_rms_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rbd_pkg::S_EMA) |-> (root_ff <= rbd_pkg::RMS_MAX))
      else $error("square root result out of range");

   a_total_with_beat: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (total_ff != $past(total_ff)))
         |-> (rsp_valid_ff && rsp_ff.beat_flag))
      else $error("beat total changed without a beat transaction");

endmodule

// File: test/rms_beat_detector_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rms_beat_detector_core_tb
// streams audio sample blocks through the beat detector and checks each block
// report against an in-bench model of the block rms, running average and beat
// decision, under several threshold settings and sender and receiver stalls
// ----------------------------------------------------------------------------
module rms_beat_detector_core_tb;

   localparam int BLOCK_LEN_MAX = 512;
   localparam int DRAIN_CYCLES  = 80;
   localparam int TIMEOUT_NS    = 10_000_000;

   localparam logic [rbd_pkg::CSR_IDX_W-1:0] CSR_SPARE       = 2'd3;
   localparam logic [rbd_pkg::SUM_W-1:0]     SQUARE_SUM_CEIL = 40'hFF_FFFF_FFFF;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_stall;
   rbd_pkg::req_type               req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_stall   = 1'b0;
   rbd_pkg::rsp_type               rsp_payload;
   logic                           csr_valid   = 1'b0;
   logic                           csr_ready;
   logic [rbd_pkg::CSR_IDX_W-1:0]  csr_index   = '0;
   logic [rbd_pkg::CSR_DATA_W-1:0] csr_data    = '0;

   rms_beat_detector_core #(
      .BLOCK_MAX(BLOCK_LEN_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // model state
   logic [rbd_pkg::SUM_W-1:0]      energy_sum    = '0;
   int unsigned                    energy_count  = 0;
   logic [rbd_pkg::AVG_W-1:0]      running_level = '0;
   bit                             level_seeded  = 1'b0;
   logic [rbd_pkg::TIME_W-1:0]     last_beat_ms  = '0;
   logic [rbd_pkg::TOTAL_W-1:0]    beat_tally    = '0;
   logic [rbd_pkg::ALPHA_W-1:0]    alpha_cfg     = rbd_pkg::ALPHA_RESET;
   logic [rbd_pkg::RATIO_W-1:0]    ratio_cfg     = rbd_pkg::RATIO_RESET;
   logic [rbd_pkg::DEBOUNCE_W-1:0] debounce_cfg  = rbd_pkg::DEBOUNCE_RESET;

   rbd_pkg::req_type sample_feed[$];
   rbd_pkg::rsp_type block_reports_due[$];
   rbd_pkg::rsp_type due_report;
   int unsigned samples_queued = 0;
   int unsigned samples_taken  = 0;
   bit          feed_taken     = 1'b0;
   int          send_idle_pct  = 0;
   int          stall_pct      = 0;
   int          mismatch_count = 0;
   logic [rbd_pkg::TIME_W-1:0] wall_ms = '0;

   function automatic logic [rbd_pkg::ROOT_W-1:0] floor_root(logic [31:0] value);
      logic [rbd_pkg::ROOT_W-1:0] root;
      logic [rbd_pkg::ROOT_W-1:0] trial;
      root = '0;
      for (int b = rbd_pkg::ROOT_W - 1; b >= 0; b--) begin
         trial = root | (rbd_pkg::ROOT_W'(1) << b);
         if (longint'(trial) * longint'(trial) <= longint'(value)) root = trial;
      end
      return root;
   endfunction

   task automatic fold_sample(rbd_pkg::req_type item);
      int                         magnitude;
      longint unsigned            widened;
      logic [31:0]                mean_square;
      logic [rbd_pkg::ROOT_W-1:0] root;
      longint unsigned            blended;
      logic [rbd_pkg::TIME_W-1:0] gap;
      rbd_pkg::rsp_type           report;
      magnitude = int'(item.sample);
      if (magnitude < 0) magnitude = -magnitude;
      widened = longint'(energy_sum) + longint'(magnitude) * longint'(magnitude);
      energy_sum = (widened > SQUARE_SUM_CEIL) ? SQUARE_SUM_CEIL
                                               : widened[rbd_pkg::SUM_W-1:0];
      energy_count++;
      if (!item.block_end && energy_count < BLOCK_LEN_MAX) return;

      mean_square = 32'(energy_sum / energy_count);
      root = floor_root(mean_square);
      if (!level_seeded) begin
         running_level = {root, 16'h0000};
         level_seeded = 1'b1;
      end
      blended = (longint'(alpha_cfg) * longint'({root, 16'h0000})
                 + (longint'(65536) - longint'(alpha_cfg)) * longint'(running_level)) >> 16;
      running_level = blended[rbd_pkg::AVG_W-1:0];

      gap = item.time_ms - last_beat_ms;
      report.beat_flag = 1'b0;
      if ((longint'(root) << 24) > longint'(running_level) * longint'(ratio_cfg)
          && gap > debounce_cfg) begin
         report.beat_flag = 1'b1;
         last_beat_ms = item.time_ms;
         beat_tally++;
      end
      energy_sum = '0;
      energy_count = 0;
      report.block_rms = root;
      report.average_level = running_level[rbd_pkg::AVG_W-1:16];
      report.beats_seen = beat_tally;
      block_reports_due.push_back(report);
   endtask

   task automatic check_field(string label, longint unsigned want, longint unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
      end
   endtask

   // monitor of both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            fold_sample(req_payload);
            samples_taken++;
            feed_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (block_reports_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: expected no transaction actual %p", $time, rsp_payload);
            end else begin
               due_report = block_reports_due.pop_front();
               check_field("beat_flag", 64'(due_report.beat_flag),
                           64'(rsp_payload.beat_flag));
               check_field("block_rms", 64'(due_report.block_rms),
                           64'(rsp_payload.block_rms));
               check_field("average_level", 64'(due_report.average_level),
                           64'(rsp_payload.average_level));
               check_field("beats_seen", 64'(due_report.beats_seen),
                           64'(rsp_payload.beats_seen));
            end
         end
      end
   end

   // sample driver and result stall
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || feed_taken) begin
         feed_taken = 1'b0;
         if (sample_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_payload <= sample_feed.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic logic signed [rbd_pkg::SAMPLE_W-1:0] draw_sample(int swing);
      if (swing >= 32767) return rbd_pkg::SAMPLE_W'($urandom);
      return rbd_pkg::SAMPLE_W'(int'($urandom_range(2 * swing)) - swing);
   endfunction

   task automatic feed_sample(logic signed [rbd_pkg::SAMPLE_W-1:0] value, logic last,
                              logic [rbd_pkg::TIME_W-1:0] stamp);
      rbd_pkg::req_type item;
      item.sample    = value;
      item.block_end = last;
      item.time_ms   = stamp;
      sample_feed.push_back(item);
      samples_queued++;
   endtask

   task automatic feed_block(int length, int swing, bit marked);
      for (int i = 0; i < length; i++) begin
         if (i == length - 1) feed_sample(draw_sample(swing), marked, wall_ms);
         else feed_sample(draw_sample(swing), 1'b0, $urandom);
      end
   endtask

   task automatic random_blocks(int budget);
      int length;
      int swing;
      while (budget > 0) begin
         length = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
         case ($urandom_range(5))
            0: swing = 0;
            1: swing = 64;
            2: swing = 1024;
            3: swing = 8192;
            4: swing = 30000;
            default: swing = 32767;
         endcase
         if ($urandom_range(19) == 0) wall_ms = $urandom;
         else wall_ms += $urandom_range(400);
         feed_block(length, swing, 1'b1);
         budget -= length;
      end
   endtask

   task automatic write_csr(logic [rbd_pkg::CSR_IDX_W-1:0] index,
                            logic [rbd_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         rbd_pkg::CSR_ALPHA:    alpha_cfg = value;
         rbd_pkg::CSR_RATIO:    ratio_cfg = value[rbd_pkg::RATIO_W-1:0];
         rbd_pkg::CSR_DEBOUNCE: debounce_cfg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_thresholds(logic [rbd_pkg::ALPHA_W-1:0] alpha,
                                 logic [rbd_pkg::RATIO_W-1:0] ratio,
                                 logic [rbd_pkg::DEBOUNCE_W-1:0] debounce);
      write_csr(rbd_pkg::CSR_ALPHA, alpha);
      write_csr(rbd_pkg::CSR_RATIO, rbd_pkg::CSR_DATA_W'(ratio));
      write_csr(rbd_pkg::CSR_DEBOUNCE, debounce);
   endtask

   task automatic drain;
      while (samples_taken != samples_queued || block_reports_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      stall_pct = 87;

      // field extremes at reset thresholds
      feed_sample(16'h7FFF, 1'b1, 32'h0000_0000);
      feed_sample(16'h8000, 1'b1, 32'd1000);
      feed_sample(16'h0000, 1'b1, 32'hFFFF_FFFF);
      feed_sample(16'h5555, 1'b0, 32'hAAAA_AAAA);
      feed_sample(16'hAAAA, 1'b1, 32'h5555_5555);
      feed_sample(16'h0001, 1'b0, 32'h0000_0000);
      feed_sample(16'hFFFF, 1'b0, 32'h0000_0000);
      feed_sample(16'h0000, 1'b1, 32'd400);
      feed_sample(16'hFFFF, 1'b1, 32'd401);
      drain;

      // zero alpha and ratio, debounce boundary
      write_csr(CSR_SPARE, 16'hFFFF);
      set_thresholds(16'd0, 12'd0, 16'd200);
      feed_sample(16'h0064, 1'b1, 32'd5000);
      feed_sample(16'h0064, 1'b1, 32'd5200);
      feed_sample(16'h0064, 1'b1, 32'd5201);
      feed_sample(16'h0000, 1'b1, 32'd6000);
      drain;

      set_thresholds(16'hFFFF, 12'hFFF, 16'hFFFF);
      random_blocks(72);
      drain;
      set_thresholds(16'h0000, 12'h000, 16'h0000);
      random_blocks(72);
      drain;

      send_idle_pct = 87;
      stall_pct = 20;
      set_thresholds(16'($urandom), 12'($urandom), 16'($urandom_range(400)));
      random_blocks(72);
      drain;
      set_thresholds(rbd_pkg::ALPHA_RESET, rbd_pkg::RATIO_RESET, rbd_pkg::DEBOUNCE_RESET);
      wall_ms = 32'hFFFF_F000;
      random_blocks(72);
      drain;

      send_idle_pct = 0;
      stall_pct = 0;
      set_thresholds(16'($urandom), 12'($urandom), 16'($urandom_range(400)));
      random_blocks(72);
      drain;
      set_thresholds(16'h8000, 12'h100, 16'd50);
      // block closed by length alone
      feed_block(BLOCK_LEN_MAX, 32767, 1'b0);
      random_blocks(72);
      drain;

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
